@@ src/rot_pkg.sv @@
// Shared types and constants for the range overlap table.
`timescale 1ns / 1ps
package rot_pkg;

	localparam int START_W = 48;
	localparam int END_W   = START_W + 1;
	localparam int HIT_W   = 6;

	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [1:0] STATUS_CLEAN     = 2'd0;
	localparam logic [1:0] STATUS_INTERSECT = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	// search token handed from cell to cell
	typedef struct packed {
		logic valid;
		logic found;
	} rot_tok_t;

endpackage

@@ src/rot_cell.sv @@
// One table cell: holds a stored range and passes the search token and entries on.
`timescale 1ns / 1ps
module rot_cell #(
	parameter int CNT_W    = 7,
	parameter int IDX_W    = 6,
	parameter int CELL_IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  logic [rot_pkg::START_W-1:0] up_start,
	input  logic [rot_pkg::END_W-1:0]   up_end,
	input  logic [rot_pkg::START_W-1:0] query_start,
	input  logic [rot_pkg::END_W-1:0]   query_end,
	input  logic [CNT_W-1:0]            count,
	input  rot_pkg::rot_tok_t           tok_in,
	input  logic [IDX_W-1:0]            pos_in,
	output logic [rot_pkg::START_W-1:0] cell_start,
	output logic [rot_pkg::END_W-1:0]   cell_end,
	output rot_pkg::rot_tok_t           tok_out,
	output logic [IDX_W-1:0]            pos_out
);
	import rot_pkg::*;

	logic [START_W-1:0] start_q;
	logic [END_W-1:0]   end_q;
	rot_tok_t           tok_q;
	logic [IDX_W-1:0]   pos_q;
	logic               occupied;
	logic               meet;

	assign occupied = CNT_W'(CELL_IDX) < count;

	// equal starts always meet; otherwise the earlier range must reach past the later start
	always_comb begin
		priority if (query_start > start_q) begin
			meet = end_q > {1'b0, query_start};
		end else if (query_start < start_q) begin
			meet = query_end > {1'b0, start_q};
		end else begin
			meet = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			start_q <= up_start;
			end_q   <= up_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.found <= tok_in.valid & (tok_in.found | (occupied & meet));
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= tok_in.found ? pos_in : IDX_W'(CELL_IDX);
	end

	assign cell_start = start_q;
	assign cell_end   = end_q;
	assign tok_out    = tok_q;
	assign pos_out    = pos_q;

endmodule

@@ src/range_overlap_table.sv @@
// Top level of the range overlap table: control, result register and the cell chain.
`timescale 1ns / 1ps
// Stores up to TABLE_DEPTH byte ranges in a shift chain of cells, newest in cell 0.
// A check item launches a search token into cell 0. The token steps one cell per cycle,
// and the check ends when it leaves the last cell; the time of a check is set by this
// walk down the chain. Clear items and checks on a full table skip the search and set
// their result directly. One item is in work at a time: the input is ready again the
// cycle after the result is loaded into the output register, so a new item can be taken
// while the previous result still waits there. A result that is still held at the output
// delays the next load by the stall.
module range_overlap_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        op,
	input  logic [rot_pkg::START_W-1:0] range_start,
	input  logic [rot_pkg::START_W-1:0] range_length,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [rot_pkg::HIT_W-1:0]   hit_index
);
	import rot_pkg::*;

	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int DIFF_W = (CNT_W > HIT_W) ? CNT_W : HIT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [START_W-1:0] query_start_q;
	logic [END_W-1:0]   query_end_q;
	logic               inject_q;
	logic [1:0]         res_status_q;
	logic [HIT_W-1:0]   res_hit_q;
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [HIT_W-1:0]   out_hit_q;

	logic               accept;
	logic               shift;
	logic               load;
	logic [DIFF_W-1:0]  hit_diff;

	logic [START_W-1:0] chain_start [TABLE_DEPTH+1];
	logic [END_W-1:0]   chain_end   [TABLE_DEPTH+1];
	rot_tok_t           chain_tok   [TABLE_DEPTH+1];
	logic [IDX_W-1:0]   chain_pos   [TABLE_DEPTH+1];
	logic [TABLE_DEPTH-1:0] tok_live;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign shift    = (state_q == ST_SCAN) & chain_tok[TABLE_DEPTH].valid;
	assign load     = (state_q == ST_DONE) & (~out_valid_q | out_ready);

	assign chain_start[0] = query_start_q;
	assign chain_end[0]   = query_end_q;
	assign chain_tok[0]   = '{valid: inject_q, found: 1'b0};
	assign chain_pos[0]   = '0;

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		rot_cell #(
			.CNT_W   (CNT_W),
			.IDX_W   (IDX_W),
			.CELL_IDX(k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (shift),
			.up_start   (chain_start[k]),
			.up_end     (chain_end[k]),
			.query_start(query_start_q),
			.query_end  (query_end_q),
			.count      (cnt_q),
			.tok_in     (chain_tok[k]),
			.pos_in     (chain_pos[k]),
			.cell_start (chain_start[k+1]),
			.cell_end   (chain_end[k+1]),
			.tok_out    (chain_tok[k+1]),
			.pos_out    (chain_pos[k+1])
		);
		assign tok_live[k] = chain_tok[k+1].valid;
	end

	// cell k holds insertion index count-1-k
	assign hit_diff = DIFF_W'(cnt_q) - DIFF_W'(1) - DIFF_W'(chain_pos[TABLE_DEPTH]);

	always_ff @(posedge clk) begin
		if (accept) begin
			query_start_q <= range_start;
			query_end_q   <= {1'b0, range_start} + {1'b0, range_length};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			inject_q     <= 1'b0;
			res_status_q <= STATUS_CLEAN;
			res_hit_q    <= '0;
		end else begin
			inject_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op == OP_CLEAR) begin
							cnt_q        <= '0;
							res_status_q <= STATUS_CLEAN;
							res_hit_q    <= '0;
							state_q      <= ST_DONE;
						end else if (cnt_q >= CNT_W'(TABLE_DEPTH)) begin
							cnt_q        <= '0;
							res_status_q <= STATUS_FULL;
							res_hit_q    <= '0;
							state_q      <= ST_DONE;
						end else begin
							inject_q <= 1'b1;
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (shift) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (chain_tok[TABLE_DEPTH].found) begin
							res_status_q <= STATUS_INTERSECT;
							res_hit_q    <= hit_diff[HIT_W-1:0];
						end else begin
							res_status_q <= STATUS_CLEAN;
							res_hit_q    <= '0;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= res_status_q;
			out_hit_q    <= res_hit_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign hit_index = out_hit_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_live))
		else $error("more than one search token in the chain");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(inject_q || (tok_live != '0)) |-> (state_q == ST_SCAN))
		else $error("search token outside of scan");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_status_q != 2'd3))
		else $error("undefined status code");

	a_shift_counts: assert property (@(posedge clk) disable iff (!arst_n)
		shift |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("insert without count update");
`endif

endmodule

@@ bench/tb_range_overlap_table.sv @@
// Testbench for range_overlap_table: directed table plus random range sequences, checked by a predictor.
`timescale 1ns / 1ps
module tb_range_overlap_table;
	import rot_pkg::*;

	localparam int DEPTH = 64;
	localparam int RANDOM_ITEMS = 1350;
	localparam int IDLE_LIMIT = 3000;
	localparam logic [START_W-1:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]       status;
		logic [HIT_W-1:0] hit;
	} verdict_t;

	typedef struct packed {
		logic               op;
		logic [START_W-1:0] start;
		logic [START_W-1:0] length;
		logic               known;
		logic [1:0]         status;
		logic [HIT_W-1:0]   hit;
	} range_row_t;

	localparam int N_ROWS = 20;

	// typed verdicts only where obvious; the rest go through the predictor
	range_row_t range_rows [N_ROWS] = '{
		'{OP_CHECK, 48'd0, 48'd0, 1'b1, STATUS_CLEAN, 6'd0},          // empty table
		'{OP_CHECK, 48'd0, 48'd5, 1'b1, STATUS_INTERSECT, 6'd0},      // equal starts
		'{OP_CHECK, 48'd5, 48'd1, 1'b1, STATUS_CLEAN, 6'd0},          // abuts end
		'{OP_CHECK, 48'd4, 48'd0, 1'b1, STATUS_INTERSECT, 6'd1},      // zero length covered
		'{OP_CHECK, MAX48, MAX48, 1'b1, STATUS_CLEAN, 6'd0},
		'{OP_CHECK, MAX48 - 48'd1, 48'd2, 1'b1, STATUS_INTERSECT, 6'd4}, // sum past 2^48
		'{OP_CHECK, 48'd0, MAX48, 1'b1, STATUS_INTERSECT, 6'd5},
		'{OP_CLEAR, MAX48, MAX48, 1'b1, STATUS_CLEAN, 6'd0},
		'{OP_CHECK, 48'd100, 48'd0, 1'b1, STATUS_CLEAN, 6'd0},
		'{OP_CHECK, 48'd100, MAX48, 1'b1, STATUS_INTERSECT, 6'd0},
		'{OP_CHECK, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 1'b0, STATUS_CLEAN, 6'd0},
		'{OP_CHECK, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b0, STATUS_CLEAN, 6'd0},
		'{OP_CHECK, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0, STATUS_CLEAN, 6'd0},
		'{OP_CLEAR, 48'd0, 48'd0, 1'b1, STATUS_CLEAN, 6'd0},
		'{OP_CHECK, 48'd10, 48'd5, 1'b1, STATUS_CLEAN, 6'd0},
		'{OP_CHECK, 48'd15, 48'd0, 1'b1, STATUS_CLEAN, 6'd0},
		'{OP_CHECK, 48'd14, 48'd0, 1'b1, STATUS_INTERSECT, 6'd0},
		'{OP_CHECK, 48'd9, 48'd1, 1'b1, STATUS_CLEAN, 6'd0},
		'{OP_CHECK, 48'd9, 48'd2, 1'b1, STATUS_INTERSECT, 6'd3},
		'{OP_CLEAR, 48'd0, 48'd0, 1'b1, STATUS_CLEAN, 6'd0}
	};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = OP_CHECK;
	logic [START_W-1:0] range_start = '0;
	logic [START_W-1:0] range_length = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic [HIT_W-1:0]   hit_index;

	logic [START_W-1:0] stored_start [DEPTH];
	logic [START_W-1:0] stored_length [DEPTH];
	int                 stored_count = 0;

	verdict_t pending_verdicts [$];
	int       error_count = 0;
	int       idle_cycles = 0;

	range_overlap_table #(.TABLE_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.range_start(range_start),
		.range_length(range_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.hit_index(hit_index)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [START_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[START_W-1:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	// exact sums, one bit wider than a start
	function automatic bit ranges_meet(logic [START_W-1:0] a, logic [START_W-1:0] a_len,
			logic [START_W-1:0] b, logic [START_W-1:0] b_len);
		if (a > b)
			return ({1'b0, b} + {1'b0, b_len}) > {1'b0, a};
		if (a < b)
			return ({1'b0, a} + {1'b0, a_len}) > {1'b0, b};
		return 1'b1;
	endfunction

	function automatic verdict_t predict_overlap(logic o, logic [START_W-1:0] s,
			logic [START_W-1:0] l);
		verdict_t v;
		int i;
		v.status = STATUS_CLEAN;
		v.hit = '0;
		if (o == OP_CLEAR) begin
			stored_count = 0;
		end else if (stored_count >= DEPTH) begin
			stored_count = 0;
			v.status = STATUS_FULL;
		end else begin
			for (i = stored_count - 1; i >= 0; i--) begin
				if (ranges_meet(s, l, stored_start[i], stored_length[i])) begin
					v.status = STATUS_INTERSECT;
					v.hit = i[HIT_W-1:0];
					break;
				end
			end
			stored_start[stored_count] = s;
			stored_length[stored_count] = l;
			stored_count++;
		end
		return v;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// leaves in_valid high; the caller lowers it before any wait
	task automatic send_item(logic o, logic [START_W-1:0] s, logic [START_W-1:0] l,
			logic known, logic [1:0] st, logic [HIT_W-1:0] hit);
		verdict_t v;
		in_valid <= 1'b1;
		op <= o;
		range_start <= s;
		range_length <= l;
		do @(posedge clk); while (!in_ready);
		v = predict_overlap(o, s, l);
		if (known) begin
			v.status = st;
			v.hit = hit;
		end
		pending_verdicts.push_back(v);
	endtask

	task automatic hold_off(int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_verdicts.size() != 0);
	endtask

	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				flag_mismatch("unexpected result, status", status, -1);
			end else begin
				v = pending_verdicts.pop_front();
				if (status !== v.status)
					flag_mismatch("status", status, v.status);
				if (hit_index !== v.hit)
					flag_mismatch("hit_index", hit_index, v.hit);
			end
		end
	end

	// receiver: stalls of random length between ready stretches
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int                 n;
		int                 k;
		int                 mode;
		int                 run_len;
		int                 sent;
		bit                 no_gaps;
		logic               o;
		logic [START_W-1:0] base;
		logic [START_W-1:0] s;
		logic [START_W-1:0] l;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < N_ROWS; n++) begin
			send_item(range_rows[n].op, range_rows[n].start, range_rows[n].length,
				range_rows[n].known, range_rows[n].status, range_rows[n].hit);
			hold_off(pick_gap());
		end
		drain_results();

		// episodes of checks with occasional clears; long runs without a clear fill the table
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 3);
			run_len = $urandom_range(1, 80);
			base = rand48();
			no_gaps = ($urandom_range(0, 3) == 0);
			for (k = 0; k < run_len; k++) begin
				case (mode)
					0: begin
						s = base + 48'($urandom_range(0, 2047));
						l = 48'($urandom_range(0, 64));
					end
					1: begin
						s = rand48();
						l = 48'($urandom_range(0, 255));
					end
					2: begin
						s = rand48();
						l = rand48();
					end
					default: begin
						s = MAX48 - 48'($urandom_range(0, 4095));
						l = $urandom_range(0, 1) ? MAX48 : 48'($urandom_range(0, 8192));
					end
				endcase
				o = ($urandom_range(0, 59) == 0) ? OP_CLEAR : OP_CHECK;
				send_item(o, s, l, 1'b0, STATUS_CLEAN, '0);
				sent++;
				if (!no_gaps)
					hold_off(pick_gap());
			end
			if ($urandom_range(0, 1)) begin
				send_item(OP_CLEAR, rand48(), rand48(), 1'b0, STATUS_CLEAN, '0);
				sent++;
				hold_off(pick_gap());
			end
			if ($urandom_range(0, 9) == 0)
				drain_results();
		end

		drain_results();
		repeat (DEPTH + 16) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
